// File: rtl/core/bffla_pkg.sv
// ----------------------------------------------------------------------------
// Best-fit allocator package
// Shared types, codes, defaults and the alignment adjustment function.
// ----------------------------------------------------------------------------
`default_nettype none

package bffla_pkg;

   // Defaults for the top-level parameters.
   localparam int MAX_EXTENTS_DEF  = 64;
   localparam int MAX_RECORDS_DEF  = 256;
   localparam int HEADER_BYTES_DEF = 16;
   localparam int OFFSET_BITS_DEF  = 32;

   // Fixed field widths.
   localparam int SIZE_BITS      = 32;
   localparam int ADDR_BITS      = 48;
   localparam int ADJ_BITS       = 8;
   localparam int ALIGN_BITS     = 3;
   localparam int LIVE_BITS      = 9;
   localparam int HDR_BITS       = 7;
   // Wide enough for any extent index up to the largest table.
   localparam int IDX_MAX_BITS   = 10;
   localparam int CSR_INDEX_BITS = 2;

   localparam logic [SIZE_BITS-1:0] HEAP_BYTES_RESET = 32'd65536;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_BITS-1:0] REG_BASE_ADDRESS = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_HEAP_BYTES   = 2'd1;

   // Request opcodes.
   localparam logic OP_ALLOCATE = 1'b0;
   localparam logic OP_FREE     = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK,
      STATUS_NO_FIT,
      STATUS_TABLE_FULL,
      STATUS_UNKNOWN_ADDR
   } status_type;

   // Operation broadcast to every cell of the extent chain.
   typedef enum logic [1:0] {
      CH_HOLD,
      CH_ROTATE,
      CH_REMOVE,
      CH_INSERT
   } chain_op_type;

   typedef struct packed {
      chain_op_type              op;
      logic [IDX_MAX_BITS-1:0]   shift_idx;
      logic                      wr_en;
      logic [IDX_MAX_BITS-1:0]   wr_idx;
   } chain_ctl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_REC_SCAN,
      ST_EXT_SCAN,
      ST_COMMIT
   } state_type;

   // Bytes between an extent start and the aligned payload. The gap is the
   // distance to the next aligned address, raised by whole alignment steps
   // until it holds at least a header.
   function automatic logic [ADJ_BITS-1:0] align_adjust(
      input logic [6:0]            addr_low,
      input logic [ALIGN_BITS-1:0] align_log2,
      input logic [HDR_BITS-1:0]   header
   );
      logic [8:0] mask;
      logic [8:0] adj;
      logic [8:0] need;
      mask = (9'd1 << align_log2) - 9'd1;
      adj  = (9'd0 - {2'b00, addr_low}) & mask;
      need = 9'd0;
      if (adj < {2'b00, header}) begin
         need = {2'b00, header} - adj;
         adj  = adj + ((need + mask) & ~mask);
      end
      return adj[ADJ_BITS-1:0];
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/bffla_cell.sv
// ----------------------------------------------------------------------------
// Extent cell
// Holds one entry of the free extent table and takes a neighbor's entry on
// rotate, remove and insert operations.
// ----------------------------------------------------------------------------
`default_nettype none

module bffla_cell #(
   parameter int CELL_INDEX  = 0,
   parameter int OFFSET_BITS = bffla_pkg::OFFSET_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire bffla_pkg::chain_ctl_type            ctl,
   input  wire logic [OFFSET_BITS-1:0]              wr_start,
   input  wire logic [bffla_pkg::SIZE_BITS-1:0]     wr_size,
   input  wire logic [OFFSET_BITS-1:0]              left_start,
   input  wire logic [bffla_pkg::SIZE_BITS-1:0]     left_size,
   input  wire logic [OFFSET_BITS-1:0]              right_start,
   input  wire logic [bffla_pkg::SIZE_BITS-1:0]     right_size,
   output logic      [OFFSET_BITS-1:0]              start_q,
   output logic      [bffla_pkg::SIZE_BITS-1:0]     size_q
);

   localparam logic [bffla_pkg::IDX_MAX_BITS-1:0] MY_IDX =
      bffla_pkg::IDX_MAX_BITS'(CELL_INDEX);

   logic [OFFSET_BITS-1:0]          start_ff, start_in;
   logic [bffla_pkg::SIZE_BITS-1:0] size_ff, size_in;

   // Select the neighbor to take from, then a direct write wins.
   always_comb begin
      start_in = start_ff;
      size_in  = size_ff;
      case (ctl.op)
         bffla_pkg::CH_ROTATE: begin
            start_in = right_start;
            size_in  = right_size;
         end
         bffla_pkg::CH_REMOVE: begin
            if (MY_IDX >= ctl.shift_idx) begin
               start_in = right_start;
               size_in  = right_size;
            end
         end
         bffla_pkg::CH_INSERT: begin
            if (MY_IDX > ctl.shift_idx) begin
               start_in = left_start;
               size_in  = left_size;
            end
         end
         default: begin
         end
      endcase
      if (ctl.wr_en && (ctl.wr_idx == MY_IDX)) begin
         start_in = wr_start;
         size_in  = wr_size;
      end
   end

   always_ff @(posedge clock) begin
      start_ff <= start_in;
      size_ff  <= size_in;
   end

   assign start_q = start_ff;
   assign size_q  = size_ff;

endmodule

`default_nettype wire

// File: rtl/core/bffla_chain.sv
// ----------------------------------------------------------------------------
// Extent chain
// A ring of extent cells; entry 0 sits at the head, which the scan reads
// while the ring rotates one place per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bffla_chain #(
   parameter int MAX_EXTENTS = bffla_pkg::MAX_EXTENTS_DEF,
   parameter int OFFSET_BITS = bffla_pkg::OFFSET_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire bffla_pkg::chain_ctl_type            ctl,
   input  wire logic [OFFSET_BITS-1:0]              wr_start,
   input  wire logic [bffla_pkg::SIZE_BITS-1:0]     wr_size,
   output logic      [OFFSET_BITS-1:0]              head_start,
   output logic      [bffla_pkg::SIZE_BITS-1:0]     head_size
);

   logic [OFFSET_BITS-1:0]          cell_start [MAX_EXTENTS];
   logic [bffla_pkg::SIZE_BITS-1:0] cell_size  [MAX_EXTENTS];

   // Each cell sees its lower and upper neighbor, closed into a ring.
   for (genvar i = 0; i < MAX_EXTENTS; i++) begin : g_cell
      localparam int LEFT  = (i == 0) ? MAX_EXTENTS - 1 : i - 1;
      localparam int RIGHT = (i == MAX_EXTENTS - 1) ? 0 : i + 1;
      bffla_cell #(
         .CELL_INDEX  (i),
         .OFFSET_BITS (OFFSET_BITS)
      ) u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .wr_start    (wr_start),
         .wr_size     (wr_size),
         .left_start  (cell_start[LEFT]),
         .left_size   (cell_size[LEFT]),
         .right_start (cell_start[RIGHT]),
         .right_size  (cell_size[RIGHT]),
         .start_q     (cell_start[i]),
         .size_q      (cell_size[i])
      );
   end

   assign head_start = cell_start[0];
   assign head_size  = cell_size[0];

endmodule

`default_nettype wire

// File: rtl/core/best_fit_free_list_allocator.sv
// ----------------------------------------------------------------------------
// Best-fit free-list allocator
// Heap allocator with an address-ordered free extent chain, an allocation
// record memory, best-fit search and coalescing on release.
// ----------------------------------------------------------------------------
// One request is handled at a time. An allocate first walks the record valid
// bits one per cycle until it finds a free slot, then rotates the extent
// chain through its head for a full pass of the ring, then commits; with no
// free slot it goes straight to commit. A free reads the record memory one
// entry per cycle until the address matches, then takes the same chain pass
// and commit. The chain pass visits each of the MAX_EXTENTS cells of the
// ring. The commit waits while a held response still fills the result
// register. The result register lets the response wait on rsp_stall while
// the next request is already accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module best_fit_free_list_allocator #(
   parameter int MAX_EXTENTS  = bffla_pkg::MAX_EXTENTS_DEF,
   parameter int MAX_RECORDS  = bffla_pkg::MAX_RECORDS_DEF,
   parameter int HEADER_BYTES = bffla_pkg::HEADER_BYTES_DEF,
   parameter int OFFSET_BITS  = bffla_pkg::OFFSET_BITS_DEF
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_stall,
   input  wire logic                                   req_opcode,
   input  wire logic [bffla_pkg::SIZE_BITS-1:0]        req_request_bytes,
   input  wire logic [bffla_pkg::ALIGN_BITS-1:0]       req_align_log2,
   input  wire logic [bffla_pkg::ADDR_BITS-1:0]        req_release_address,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_stall,
   output logic      [1:0]                             rsp_status,
   output logic      [bffla_pkg::ADDR_BITS-1:0]        rsp_granted_address,
   output logic      [bffla_pkg::SIZE_BITS-1:0]        rsp_bytes_in_use,
   output logic      [bffla_pkg::LIVE_BITS-1:0]        rsp_live_count,
   input  wire logic                                   csr_valid,
   output logic                                        csr_ready,
   input  wire logic [bffla_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [bffla_pkg::ADDR_BITS-1:0]        csr_wdata
);

   localparam int SZ  = bffla_pkg::SIZE_BITS;
   localparam int AB  = bffla_pkg::ADDR_BITS;
   localparam int OW  = OFFSET_BITS;
   localparam int IW  = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
   localparam int CW  = $clog2(MAX_EXTENTS + 1);
   localparam int RW  = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
   localparam int ACW = $clog2(MAX_RECORDS + 1);
   localparam int SW  = ((OW > SZ) ? OW : SZ) + 1;
   localparam int TW  = SZ + 1;
   localparam int IXB = bffla_pkg::IDX_MAX_BITS;

   localparam logic [AB:0]     OFF_MAX   = (49'd1 << OFFSET_BITS) - 49'd1;
   localparam logic [IW-1:0]   EXT_LAST  = IW'(MAX_EXTENTS - 1);
   localparam logic [RW-1:0]   REC_LAST  = RW'(MAX_RECORDS - 1);
   localparam logic [CW-1:0]   EXT_FULL  = CW'(MAX_EXTENTS);
   localparam logic [TW-1:0]   HDR_TW    = TW'(HEADER_BYTES);
   localparam logic [bffla_pkg::HDR_BITS-1:0] HDR_NARROW =
      bffla_pkg::HDR_BITS'(HEADER_BYTES);

   // ------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------
   bffla_pkg::state_type   state_ff, state_in;
   bffla_pkg::status_type  status_ff, status_in;

   logic [AB-1:0]   base_ff, base_in;
   logic            op_ff, op_in;
   logic [SZ-1:0]   req_bytes_ff, req_bytes_in;
   logic [2:0]      align_ff, align_in;
   logic [AB-1:0]   rel_addr_ff, rel_addr_in;

   logic [RW-1:0]   rec_idx_ff, rec_idx_in;
   logic            issue_done_ff, issue_done_in;
   logic            rd_pend_ff, rd_pend_in;
   logic            rd_last_ff, rd_last_in;
   logic [RW-1:0]   rd_idx_ff, rd_idx_in;
   logic            rd_valid_ff, rd_valid_in;
   logic [OW-1:0]   rq_addr_ff;
   logic [SZ-1:0]   rq_size_ff;
   logic [7:0]      rq_adj_ff;
   logic [RW-1:0]   slot_ff, slot_in;

   logic [IW-1:0]   ext_idx_ff, ext_idx_in;
   logic [CW-1:0]   ext_count_ff, ext_count_in;

   logic            best_found_ff, best_found_in;
   logic            exact_ff, exact_in;
   logic [IW-1:0]   best_idx_ff, best_idx_in;
   logic [7:0]      best_adj_ff, best_adj_in;
   logic [TW-1:0]   best_total_ff, best_total_in;
   logic [OW-1:0]   best_start_ff, best_start_in;
   logic [SZ-1:0]   best_size_ff, best_size_in;

   logic [OW-1:0]   bs_ff, bs_in;
   logic [SZ-1:0]   bsz_ff, bsz_in;
   logic [SW-1:0]   be_ff, be_in;
   logic            p_found_ff, p_found_in;
   logic [CW-1:0]   p_idx_ff, p_idx_in;
   logic            has_prev_ff, has_prev_in;
   logic [OW-1:0]   prev_start_ff, prev_start_in;
   logic [SZ-1:0]   prev_size_ff, prev_size_in;
   logic [OW-1:0]   next_start_ff, next_start_in;
   logic [SZ-1:0]   next_size_ff, next_size_in;

   logic [SZ-1:0]          used_ff, used_in;
   logic [ACW-1:0]         alloc_cnt_ff, alloc_cnt_in;
   logic [MAX_RECORDS-1:0] rec_valid_ff, rec_valid_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   bffla_pkg::status_type  rsp_status_ff, rsp_status_in;
   logic [AB-1:0]          rsp_granted_ff, rsp_granted_in;
   logic [SZ-1:0]          rsp_bytes_ff, rsp_bytes_in;
   logic [bffla_pkg::LIVE_BITS-1:0] rsp_live_ff, rsp_live_in;

   // Allocation record memory.
   logic [OW-1:0] rec_addr_mem [MAX_RECORDS];
   logic [SZ-1:0] rec_size_mem [MAX_RECORDS];
   logic [7:0]    rec_adj_mem  [MAX_RECORDS];

   // ------------------------------------------------------------------
   // Handshakes and decoded conditions
   // ------------------------------------------------------------------
   logic req_accept, cfg_write, cfg_base, cfg_heap, alloc_op;
   logic rq_match, rec_hit, rec_miss, issue, commit_go;
   logic [OW-1:0]  rec_bs;
   logic [SW-1:0]  rec_be;

   assign req_accept = req_valid && !req_stall;
   assign cfg_write  = csr_valid && csr_ready;
   assign cfg_base   = cfg_write && (csr_index == bffla_pkg::REG_BASE_ADDRESS);
   assign cfg_heap   = cfg_write && (csr_index == bffla_pkg::REG_HEAP_BYTES);
   assign alloc_op   = (op_ff == bffla_pkg::OP_ALLOCATE);
   assign commit_go  = (state_ff == bffla_pkg::ST_COMMIT) && (!rsp_valid_ff || !rsp_stall);

   // Record lookup: valid bits for a free slot, memory data for an address.
   assign rq_match = AB'(base_ff + AB'(rq_addr_ff)) == rel_addr_ff;
   assign issue    = (state_ff == bffla_pkg::ST_REC_SCAN) && !alloc_op && !issue_done_ff;
   always_comb begin
      if (alloc_op) begin
         rec_hit  = !rec_valid_ff[rec_idx_ff];
         rec_miss = rec_valid_ff[rec_idx_ff] && (rec_idx_ff == REC_LAST);
      end else begin
         rec_hit  = rd_pend_ff && rd_valid_ff && rq_match;
         rec_miss = rd_pend_ff && rd_last_ff && !(rd_valid_ff && rq_match);
      end
   end
   assign rec_bs = OW'(rq_addr_ff - OW'(rq_adj_ff));
   assign rec_be = SW'(rec_bs) + SW'(rq_size_ff);

   // ------------------------------------------------------------------
   // Extent chain and head evaluation
   // ------------------------------------------------------------------
   bffla_pkg::chain_ctl_type chain_ctl;
   logic [OW-1:0] chain_wr_start, head_start;
   logic [SZ-1:0] chain_wr_size, head_size;

   bffla_chain #(
      .MAX_EXTENTS (MAX_EXTENTS),
      .OFFSET_BITS (OFFSET_BITS)
   ) u_chain (
      .clock      (clock),
      .ctl        (chain_ctl),
      .wr_start   (chain_wr_start),
      .wr_size    (chain_wr_size),
      .head_start (head_start),
      .head_size  (head_size)
   );

   logic          head_ok, head_fits, head_take, head_exact, head_after;
   logic [7:0]    head_adj;
   logic [TW-1:0] head_total;

   // Fit test for the entry now at the head of the ring.
   always_comb begin
      head_ok    = CW'(ext_idx_ff) < ext_count_ff;
      head_adj   = bffla_pkg::align_adjust(7'(base_ff[6:0] + head_start[6:0]),
                                           align_ff, HDR_NARROW);
      head_total = {1'b0, req_bytes_ff} + TW'(head_adj);
      head_fits  = {1'b0, head_size} >= head_total;
      head_exact = {1'b0, head_size} == head_total;
      head_take  = head_ok && !exact_ff && head_fits &&
                   (!best_found_ff || (head_size < best_size_ff));
      head_after = head_ok && !p_found_ff && (SW'(head_start) >= be_ff);
   end

   // ------------------------------------------------------------------
   // Commit decisions
   // ------------------------------------------------------------------
   logic [TW-1:0] remain;
   logic          take_whole, merge_prev, merge_next, free_full;
   logic [SZ-1:0] take;
   logic [OW-1:0] rec_off, split_start;
   logic [SZ-1:0] split_size;
   logic [AB-1:0] granted;
   bffla_pkg::status_type final_status;

   always_comb begin
      remain      = {1'b0, best_size_ff} - best_total_ff;
      take_whole  = remain <= HDR_TW;
      take        = take_whole ? best_size_ff : best_total_ff[SZ-1:0];
      rec_off     = OW'(best_start_ff + OW'(best_adj_ff));
      split_start = OW'(best_start_ff + OW'(best_total_ff));
      split_size  = best_size_ff - best_total_ff[SZ-1:0];
      granted     = AB'(base_ff + AB'(rec_off));
      merge_prev  = has_prev_ff && (SW'(prev_start_ff) + SW'(prev_size_ff) == SW'(bs_ff));
      merge_next  = p_found_ff && (be_ff == SW'(next_start_ff));
      free_full   = !merge_prev && !merge_next && (ext_count_ff >= EXT_FULL);
      final_status = status_ff;
      if (status_ff == bffla_pkg::STATUS_OK) begin
         if (alloc_op) begin
            if (!best_found_ff) begin
               final_status = bffla_pkg::STATUS_NO_FIT;
            end
         end else if (free_full) begin
            final_status = bffla_pkg::STATUS_TABLE_FULL;
         end
      end
   end

   // ------------------------------------------------------------------
   // Next state
   // ------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bffla_pkg::ST_IDLE: begin
            if (req_accept) state_in = bffla_pkg::ST_REC_SCAN;
         end
         bffla_pkg::ST_REC_SCAN: begin
            if (rec_hit) state_in = bffla_pkg::ST_EXT_SCAN;
            else if (rec_miss) state_in = bffla_pkg::ST_COMMIT;
         end
         bffla_pkg::ST_EXT_SCAN: begin
            if (ext_idx_ff == EXT_LAST) state_in = bffla_pkg::ST_COMMIT;
         end
         bffla_pkg::ST_COMMIT: begin
            if (commit_go) state_in = bffla_pkg::ST_IDLE;
         end
         default: state_in = bffla_pkg::ST_IDLE;
      endcase
   end

   // ------------------------------------------------------------------
   // Outputs of the state machine: stall and chain control
   // ------------------------------------------------------------------
   logic [SZ-1:0] heap_src, heap_sat;

   always_comb begin
      heap_src = reset ? bffla_pkg::HEAP_BYTES_RESET : csr_wdata[SZ-1:0];
      heap_sat = ({17'd0, heap_src} > OFF_MAX) ? OFF_MAX[SZ-1:0] : heap_src;
   end

   always_comb begin
      req_stall      = (state_ff != bffla_pkg::ST_IDLE);
      chain_ctl      = '{op: bffla_pkg::CH_HOLD, shift_idx: '0, wr_en: 1'b0, wr_idx: '0};
      chain_wr_start = '0;
      chain_wr_size  = '0;
      if (reset || cfg_heap) begin
         // Heap restart: a single extent covering the whole region.
         chain_ctl.wr_en = 1'b1;
         chain_wr_size   = heap_sat;
      end else begin
         case (state_ff)
            bffla_pkg::ST_EXT_SCAN: chain_ctl.op = bffla_pkg::CH_ROTATE;
            bffla_pkg::ST_COMMIT: begin
               if (commit_go && (final_status == bffla_pkg::STATUS_OK)) begin
                  if (alloc_op) begin
                     if (take_whole) begin
                        chain_ctl.op        = bffla_pkg::CH_REMOVE;
                        chain_ctl.shift_idx = IXB'(best_idx_ff);
                     end else begin
                        chain_ctl.wr_en = 1'b1;
                        chain_ctl.wr_idx = IXB'(best_idx_ff);
                        chain_wr_start  = split_start;
                        chain_wr_size   = split_size;
                     end
                  end else if (merge_prev && merge_next) begin
                     chain_ctl.op        = bffla_pkg::CH_REMOVE;
                     chain_ctl.shift_idx = IXB'(p_idx_ff);
                     chain_ctl.wr_en     = 1'b1;
                     chain_ctl.wr_idx    = IXB'(p_idx_ff - CW'(1));
                     chain_wr_start      = prev_start_ff;
                     chain_wr_size       = prev_size_ff + bsz_ff + next_size_ff;
                  end else if (merge_prev) begin
                     chain_ctl.wr_en  = 1'b1;
                     chain_ctl.wr_idx = IXB'(p_idx_ff - CW'(1));
                     chain_wr_start   = prev_start_ff;
                     chain_wr_size    = prev_size_ff + bsz_ff;
                  end else if (merge_next) begin
                     chain_ctl.wr_en  = 1'b1;
                     chain_ctl.wr_idx = IXB'(p_idx_ff);
                     chain_wr_start   = bs_ff;
                     chain_wr_size    = next_size_ff + bsz_ff;
                  end else begin
                     chain_ctl.op        = bffla_pkg::CH_INSERT;
                     chain_ctl.shift_idx = IXB'(p_idx_ff);
                     chain_ctl.wr_en     = 1'b1;
                     chain_ctl.wr_idx    = IXB'(p_idx_ff);
                     chain_wr_start      = bs_ff;
                     chain_wr_size       = bsz_ff;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Datapath next values
   // ------------------------------------------------------------------
   logic rec_set, rec_clr;

   always_comb begin
      base_in       = base_ff;
      op_in         = op_ff;
      req_bytes_in  = req_bytes_ff;
      align_in      = align_ff;
      rel_addr_in   = rel_addr_ff;
      status_in     = status_ff;
      rec_idx_in    = rec_idx_ff;
      issue_done_in = issue_done_ff;
      rd_pend_in    = issue;
      rd_last_in    = (rec_idx_ff == REC_LAST);
      rd_idx_in     = rec_idx_ff;
      rd_valid_in   = rec_valid_ff[rec_idx_ff];
      slot_in       = slot_ff;
      ext_idx_in    = ext_idx_ff;
      ext_count_in  = ext_count_ff;
      best_found_in = best_found_ff;
      exact_in      = exact_ff;
      best_idx_in   = best_idx_ff;
      best_adj_in   = best_adj_ff;
      best_total_in = best_total_ff;
      best_start_in = best_start_ff;
      best_size_in  = best_size_ff;
      bs_in         = bs_ff;
      bsz_in        = bsz_ff;
      be_in         = be_ff;
      p_found_in    = p_found_ff;
      p_idx_in      = p_idx_ff;
      has_prev_in   = has_prev_ff;
      prev_start_in = prev_start_ff;
      prev_size_in  = prev_size_ff;
      next_start_in = next_start_ff;
      next_size_in  = next_size_ff;
      used_in       = used_ff;
      alloc_cnt_in  = alloc_cnt_ff;
      rec_valid_in  = rec_valid_ff;
      rec_set       = 1'b0;
      rec_clr       = 1'b0;

      // Response register drains on a transfer.
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_status_in  = rsp_status_ff;
      rsp_granted_in = rsp_granted_ff;
      rsp_bytes_in   = rsp_bytes_ff;
      rsp_live_in    = rsp_live_ff;

      case (state_ff)
         bffla_pkg::ST_IDLE: begin
            if (req_accept) begin
               op_in         = req_opcode;
               req_bytes_in  = req_request_bytes;
               align_in      = req_align_log2;
               rel_addr_in   = req_release_address;
               status_in     = bffla_pkg::STATUS_OK;
               rec_idx_in    = '0;
               issue_done_in = 1'b0;
            end
         end
         bffla_pkg::ST_REC_SCAN: begin
            if (rec_hit) begin
               slot_in       = alloc_op ? rec_idx_ff : rd_idx_ff;
               bs_in         = rec_bs;
               bsz_in        = rq_size_ff;
               be_in         = rec_be;
               ext_idx_in    = '0;
               best_found_in = 1'b0;
               exact_in      = 1'b0;
               p_found_in    = 1'b0;
               p_idx_in      = ext_count_ff;
               has_prev_in   = 1'b0;
            end else if (rec_miss) begin
               status_in = alloc_op ? bffla_pkg::STATUS_TABLE_FULL
                                    : bffla_pkg::STATUS_UNKNOWN_ADDR;
            end else if (alloc_op || issue) begin
               if (rec_idx_ff == REC_LAST) issue_done_in = 1'b1;
               else rec_idx_in = rec_idx_ff + RW'(1);
            end
         end
         bffla_pkg::ST_EXT_SCAN: begin
            ext_idx_in = (ext_idx_ff == EXT_LAST) ? '0 : ext_idx_ff + IW'(1);
            if (alloc_op) begin
               if (head_take) begin
                  best_found_in = 1'b1;
                  exact_in      = head_exact;
                  best_idx_in   = ext_idx_ff;
                  best_adj_in   = head_adj;
                  best_total_in = head_total;
                  best_start_in = head_start;
                  best_size_in  = head_size;
               end
            end else if (head_after) begin
               p_found_in    = 1'b1;
               p_idx_in      = CW'(ext_idx_ff);
               next_start_in = head_start;
               next_size_in  = head_size;
            end else if (head_ok && !p_found_ff) begin
               has_prev_in   = 1'b1;
               prev_start_in = head_start;
               prev_size_in  = head_size;
            end
         end
         bffla_pkg::ST_COMMIT: begin
            if (commit_go) begin
               if (final_status == bffla_pkg::STATUS_OK) begin
                  if (alloc_op) begin
                     rec_set      = 1'b1;
                     used_in      = used_ff + take;
                     alloc_cnt_in = alloc_cnt_ff + ACW'(1);
                     if (take_whole) ext_count_in = ext_count_ff - CW'(1);
                  end else begin
                     rec_clr = 1'b1;
                     used_in = used_ff - bsz_ff;
                     if (alloc_cnt_ff != '0) alloc_cnt_in = alloc_cnt_ff - ACW'(1);
                     if (merge_prev && merge_next) ext_count_in = ext_count_ff - CW'(1);
                     else if (!merge_prev && !merge_next) ext_count_in = ext_count_ff + CW'(1);
                  end
               end
               rsp_valid_in   = 1'b1;
               rsp_status_in  = final_status;
               rsp_granted_in = (alloc_op && (final_status == bffla_pkg::STATUS_OK))
                                ? granted : '0;
               rsp_bytes_in   = used_in;
               rsp_live_in    = (32'(alloc_cnt_in) > 32'd511) ? 9'd511
                                : bffla_pkg::LIVE_BITS'(alloc_cnt_in);
            end
         end
         default: begin
         end
      endcase

      if (rec_set) rec_valid_in[slot_ff] = 1'b1;
      if (rec_clr) rec_valid_in[slot_ff] = 1'b0;

      // Configuration writes must arrive only while idle; the block itself does not enforce this.
      if (cfg_base) base_in = csr_wdata;
      if (cfg_heap) begin
         ext_count_in = CW'(1);
         used_in      = '0;
         alloc_cnt_in = '0;
         rec_valid_in = '0;
      end
   end

   // ------------------------------------------------------------------
   // Control registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= bffla_pkg::ST_IDLE;
         base_ff       <= '0;
         ext_count_ff  <= CW'(1);
         used_ff       <= '0;
         alloc_cnt_ff  <= '0;
         rec_valid_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
         issue_done_ff <= 1'b0;
         rd_pend_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         base_ff       <= base_in;
         ext_count_ff  <= ext_count_in;
         used_ff       <= used_in;
         alloc_cnt_ff  <= alloc_cnt_in;
         rec_valid_ff  <= rec_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         issue_done_ff <= issue_done_in;
         rd_pend_ff    <= rd_pend_in;
      end
   end

   // ------------------------------------------------------------------
   // Payload registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      req_bytes_ff   <= req_bytes_in;
      align_ff       <= align_in;
      rel_addr_ff    <= rel_addr_in;
      status_ff      <= status_in;
      rec_idx_ff     <= rec_idx_in;
      rd_last_ff     <= rd_last_in;
      rd_idx_ff      <= rd_idx_in;
      rd_valid_ff    <= rd_valid_in;
      slot_ff        <= slot_in;
      ext_idx_ff     <= ext_idx_in;
      best_found_ff  <= best_found_in;
      exact_ff       <= exact_in;
      best_idx_ff    <= best_idx_in;
      best_adj_ff    <= best_adj_in;
      best_total_ff  <= best_total_in;
      best_start_ff  <= best_start_in;
      best_size_ff   <= best_size_in;
      bs_ff          <= bs_in;
      bsz_ff         <= bsz_in;
      be_ff          <= be_in;
      p_found_ff     <= p_found_in;
      p_idx_ff       <= p_idx_in;
      has_prev_ff    <= has_prev_in;
      prev_start_ff  <= prev_start_in;
      prev_size_ff   <= prev_size_in;
      next_start_ff  <= next_start_in;
      next_size_ff   <= next_size_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_bytes_ff   <= rsp_bytes_in;
      rsp_live_ff    <= rsp_live_in;
   end

   // ------------------------------------------------------------------
   // Record memory: one write port at commit, one registered read port
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (rec_set) begin
         rec_addr_mem[slot_ff] <= rec_off;
         rec_size_mem[slot_ff] <= take;
         rec_adj_mem[slot_ff]  <= best_adj_ff;
      end
      rq_addr_ff <= rec_addr_mem[rec_idx_ff];
      rq_size_ff <= rec_size_mem[rec_idx_ff];
      rq_adj_ff  <= rec_adj_mem[rec_idx_ff];
   end

   // ------------------------------------------------------------------
   // Ports
   // ------------------------------------------------------------------
   assign csr_ready           = 1'b1;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_granted_address = rsp_granted_ff;
   assign rsp_bytes_in_use    = rsp_bytes_ff;
   assign rsp_live_count      = rsp_live_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   a_ext_count_bound : assert property (@(posedge clock) disable iff (reset)
      ext_count_ff <= EXT_FULL)
      else $error("extent count exceeds table size");

   a_live_matches_valid : assert property (@(posedge clock) disable iff (reset)
      alloc_cnt_ff == ACW'($countones(rec_valid_ff)))
      else $error("live count differs from record valid bits");

   a_rsp_from_commit : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == bffla_pkg::ST_COMMIT))
      else $error("response raised outside commit");

   a_full_rotation : assert property (@(posedge clock) disable iff (reset)
      (state_ff == bffla_pkg::ST_EXT_SCAN && state_in != bffla_pkg::ST_EXT_SCAN)
      |-> (ext_idx_ff == EXT_LAST))
      else $error("extent chain left before a full rotation");

endmodule

`default_nettype wire

// File: sim/tb_best_fit_free_list_allocator.sv
// ----------------------------------------------------------------------------
// Best-fit allocator testbench
// Drives allocate and free requests and writes the registers between phases.
// A local copy of the extent and record tables predicts each response, and
// every response is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_best_fit_free_list_allocator;

   localparam int NUM_EXTENTS    = bffla_pkg::MAX_EXTENTS_DEF;
   localparam int NUM_RECORDS    = bffla_pkg::MAX_RECORDS_DEF;
   localparam int HDR            = bffla_pkg::HEADER_BYTES_DEF;
   localparam int ADDR_BITS      = bffla_pkg::ADDR_BITS;
   localparam int SIZE_BITS      = bffla_pkg::SIZE_BITS;
   localparam int LIVE_BITS      = bffla_pkg::LIVE_BITS;
   localparam int ALIGN_BITS     = bffla_pkg::ALIGN_BITS;
   localparam int CSR_INDEX_BITS = bffla_pkg::CSR_INDEX_BITS;
   localparam int SETTLE         = 400;
   localparam int HOLD_CYCLES    = 600;

   typedef struct {
      bffla_pkg::status_type   status;
      logic [ADDR_BITS-1:0]    granted;
      logic [SIZE_BITS-1:0]    in_use;
      logic [LIVE_BITS-1:0]    live;
   } response_type;

   logic                        clock;
   logic                        reset;
   logic                        req_valid;
   logic                        req_stall;
   logic                        req_opcode;
   logic [SIZE_BITS-1:0]        req_request_bytes;
   logic [ALIGN_BITS-1:0]       req_align_log2;
   logic [ADDR_BITS-1:0]        req_release_address;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic [1:0]                  rsp_status;
   logic [ADDR_BITS-1:0]        rsp_granted_address;
   logic [SIZE_BITS-1:0]        rsp_bytes_in_use;
   logic [LIVE_BITS-1:0]        rsp_live_count;
   logic                        csr_valid;
   logic                        csr_ready;
   logic [CSR_INDEX_BITS-1:0]   csr_index;
   logic [ADDR_BITS-1:0]        csr_wdata;

   best_fit_free_list_allocator DUT (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_opcode          (req_opcode),
      .req_request_bytes   (req_request_bytes),
      .req_align_log2      (req_align_log2),
      .req_release_address (req_release_address),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_status          (rsp_status),
      .rsp_granted_address (rsp_granted_address),
      .rsp_bytes_in_use    (rsp_bytes_in_use),
      .rsp_live_count      (rsp_live_count),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   // Shadow copy of the heap state.
   logic [ADDR_BITS-1:0]  shadow_base;
   logic [SIZE_BITS-1:0]  shadow_heap;
   logic [31:0]           ext_start [NUM_EXTENTS];
   logic [31:0]           ext_size [NUM_EXTENTS];
   int                    ext_count;
   logic [31:0]           rec_addr [NUM_RECORDS];
   logic [31:0]           rec_size [NUM_RECORDS];
   logic [7:0]            rec_adj [NUM_RECORDS];
   bit                    rec_valid [NUM_RECORDS];
   logic [31:0]           used_bytes;
   int                    live_allocs;

   response_type          pending_responses [$];
   logic [ADDR_BITS-1:0]  live_addresses [$];
   logic [ADDR_BITS-1:0]  released_addresses [$];
   int                    mismatch_count;
   int                    send_idle_pct;
   int                    recv_idle_pct;
   int                    hold_requests = 0;
   int                    hold_seen = 0;
   int                    hold_left = 0;

   // Clock.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog on the whole run.
   initial begin
      #100000000;
      $display("Mismatches found");
      $finish;
   end

   function automatic void heap_clear();
      ext_start[0] = '0;
      ext_size[0]  = shadow_heap;
      ext_count    = 1;
      for (int i = 0; i < NUM_RECORDS; i++) begin
         rec_valid[i] = 1'b0;
      end
      used_bytes  = '0;
      live_allocs = 0;
      live_addresses.delete();
      released_addresses.delete();
   endfunction

   // Gap from an extent start to the aligned payload, at least one header.
   function automatic longint unsigned payload_gap(logic [31:0] offset,
                                                   logic [2:0] align_log2);
      longint unsigned align;
      longint unsigned gap;
      logic [ADDR_BITS-1:0] addr;
      align = 64'd1 << align_log2;
      addr  = shadow_base + offset;
      gap   = (align - (addr & (align - 1))) & (align - 1);
      if (gap < HDR) begin
         gap += ((HDR - gap + align - 1) / align) * align;
      end
      return gap;
   endfunction

   function automatic response_type allocate_block(logic [31:0] bytes,
                                                   logic [2:0] align_log2);
      response_type    resp;
      int              slot;
      int              best;
      bit              found;
      longint unsigned gap;
      longint unsigned total;
      longint unsigned best_gap;
      longint unsigned best_total;
      longint unsigned take;
      resp.status  = bffla_pkg::STATUS_OK;
      resp.granted = '0;
      slot  = NUM_RECORDS;
      best  = 0;
      found = 1'b0;
      best_gap   = 0;
      best_total = 0;
      for (int s = NUM_RECORDS - 1; s >= 0; s--) begin
         if (!rec_valid[s]) slot = s;
      end
      if (slot == NUM_RECORDS) begin
         resp.status = bffla_pkg::STATUS_TABLE_FULL;
         return resp;
      end
      // Best-fit scan, lowest address wins ties, exact fit stops the search.
      for (int i = 0; i < ext_count; i++) begin
         gap   = payload_gap(ext_start[i], align_log2);
         total = longint'(bytes) + gap;
         if (ext_size[i] >= total && (!found || ext_size[i] < ext_size[best])) begin
            found      = 1'b1;
            best       = i;
            best_gap   = gap;
            best_total = total;
            if (ext_size[i] == total) break;
         end
      end
      if (!found) begin
         resp.status = bffla_pkg::STATUS_NO_FIT;
         return resp;
      end
      take = best_total;
      rec_addr[slot] = ext_start[best] + best_gap[31:0];
      if (ext_size[best] - best_total <= HDR) begin
         take = 64'(ext_size[best]);
         for (int i = best; i + 1 < ext_count; i++) begin
            ext_start[i] = ext_start[i + 1];
            ext_size[i]  = ext_size[i + 1];
         end
         ext_count--;
      end else begin
         ext_start[best] = ext_start[best] + best_total[31:0];
         ext_size[best]  = ext_size[best] - best_total[31:0];
      end
      rec_size[slot]  = take[31:0];
      rec_adj[slot]   = best_gap[7:0];
      rec_valid[slot] = 1'b1;
      used_bytes      = used_bytes + take[31:0];
      live_allocs++;
      resp.granted = shadow_base + rec_addr[slot];
      live_addresses.push_back(resp.granted);
      return resp;
   endfunction

   function automatic response_type release_block(logic [ADDR_BITS-1:0] address);
      response_type    resp;
      int              r;
      int              p;
      logic [31:0]     blk_start;
      logic [31:0]     blk_size;
      longint unsigned blk_end;
      bit              join_prev;
      bit              join_next;
      resp.status  = bffla_pkg::STATUS_OK;
      resp.granted = '0;
      r = NUM_RECORDS;
      for (int s = NUM_RECORDS - 1; s >= 0; s--) begin
         if (rec_valid[s] && ADDR_BITS'(shadow_base + rec_addr[s]) == address) r = s;
      end
      if (r == NUM_RECORDS) begin
         resp.status = bffla_pkg::STATUS_UNKNOWN_ADDR;
         return resp;
      end
      blk_start = rec_addr[r] - rec_adj[r];
      blk_size  = rec_size[r];
      blk_end   = longint'(blk_start) + blk_size;
      p = ext_count;
      for (int i = ext_count - 1; i >= 0; i--) begin
         if (ext_start[i] >= blk_end) p = i;
      end
      join_prev = p > 0 && longint'(ext_start[p - 1]) + ext_size[p - 1] == blk_start;
      join_next = p < ext_count && blk_end == ext_start[p];
      // Coalesce with free neighbors, or insert a new extent in order.
      if (join_prev && join_next) begin
         ext_size[p - 1] = ext_size[p - 1] + blk_size + ext_size[p];
         for (int i = p; i + 1 < ext_count; i++) begin
            ext_start[i] = ext_start[i + 1];
            ext_size[i]  = ext_size[i + 1];
         end
         ext_count--;
      end else if (join_prev) begin
         ext_size[p - 1] = ext_size[p - 1] + blk_size;
      end else if (join_next) begin
         ext_start[p] = blk_start;
         ext_size[p]  = ext_size[p] + blk_size;
      end else begin
         if (ext_count >= NUM_EXTENTS) begin
            resp.status = bffla_pkg::STATUS_TABLE_FULL;
            return resp;
         end
         for (int i = ext_count; i > p; i--) begin
            ext_start[i] = ext_start[i - 1];
            ext_size[i]  = ext_size[i - 1];
         end
         ext_start[p] = blk_start;
         ext_size[p]  = blk_size;
         ext_count++;
      end
      rec_valid[r] = 1'b0;
      used_bytes   = used_bytes - blk_size;
      if (live_allocs > 0) live_allocs--;
      foreach (live_addresses[k]) begin
         if (live_addresses[k] == address) begin
            live_addresses.delete(k);
            break;
         end
      end
      released_addresses.push_back(address);
      if (released_addresses.size() > 32) void'(released_addresses.pop_front());
      return resp;
   endfunction

   function automatic void predict_response(logic opcode, logic [31:0] bytes,
                                            logic [2:0] align_log2,
                                            logic [ADDR_BITS-1:0] address);
      response_type resp;
      if (opcode == bffla_pkg::OP_ALLOCATE) resp = allocate_block(bytes, align_log2);
      else                                  resp = release_block(address);
      resp.in_use = used_bytes;
      resp.live   = live_allocs > 511 ? 9'd511 : LIVE_BITS'(live_allocs);
      pending_responses.push_back(resp);
   endfunction

   // Send one request; the valid stays high for a following request.
   task automatic send_request(logic opcode, logic [31:0] bytes,
                               logic [2:0] align_log2, logic [ADDR_BITS-1:0] address);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_opcode          <= opcode;
      req_request_bytes   <= bytes;
      req_align_log2      <= align_log2;
      req_release_address <= address;
      do @(posedge clock); while (req_stall);
      predict_response(opcode, bytes, align_log2, address);
   endtask

   task automatic allocate(logic [31:0] bytes, logic [2:0] align_log2);
      send_request(bffla_pkg::OP_ALLOCATE, bytes, align_log2, ADDR_BITS'($urandom()));
   endtask

   task automatic release_addr(logic [ADDR_BITS-1:0] address);
      send_request(bffla_pkg::OP_FREE, $urandom(), ALIGN_BITS'($urandom()), address);
   endtask

   // Free a random live allocation, or a random address if there is none.
   task automatic release_random_live();
      if (live_addresses.size() == 0) begin
         release_addr(ADDR_BITS'({$urandom(), $urandom()}));
      end else begin
         release_addr(live_addresses[$urandom_range(0, live_addresses.size() - 1)]);
      end
   endtask

   // Stop sending and wait until every response has arrived.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_responses.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_register(logic [CSR_INDEX_BITS-1:0] index,
                                 logic [ADDR_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (index == bffla_pkg::REG_BASE_ADDRESS) begin
         shadow_base = data;
      end else if (index == bffla_pkg::REG_HEAP_BYTES) begin
         shadow_heap = data[SIZE_BITS-1:0];
         heap_clear();
      end
      @(posedge clock);
   endtask

   // Long receiver hold, counted in cycles.
   always @(posedge clock) begin
      if (hold_requests != hold_seen) begin
         hold_seen <= hold_requests;
         hold_left <= HOLD_CYCLES;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Response checker and receiver stall generator.
   always @(posedge clock) begin
      response_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_responses.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("Unexpected response transfer");
         end else begin
            want = pending_responses.pop_front();
            if (rsp_status !== want.status || rsp_granted_address !== want.granted ||
                rsp_bytes_in_use !== want.in_use || rsp_live_count !== want.live) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("Response mismatch: expected status %0d addr %h used %0d live %0d",
                           want.status, want.granted, want.in_use, want.live);
                  $display("                   actual   status %0d addr %h used %0d live %0d",
                           rsp_status, rsp_granted_address, rsp_bytes_in_use,
                           rsp_live_count);
               end
            end
         end
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= $urandom_range(0, 99) < recv_idle_pct;
      end
   end

   // Edge sizes, every alignment, exact fits, whole-extent takes, bad frees.
   task automatic test_directed();
      logic [ADDR_BITS-1:0] first;
      allocate(32'd0, 3'd0);
      first = live_addresses[0];
      allocate(32'd1, 3'd7);
      allocate(32'hFFFF_FFFF, 3'd3);
      for (int a = 1; a < 7; a++) allocate(32'd24 + a, a[2:0]);
      release_addr(first);
      release_addr(first);
      release_addr(48'hFFFF_FFFF_FFFF);
      while (live_addresses.size() != 0) release_random_live();
      // The whole heap as one exact fit, then a take whose small tail is taken whole.
      allocate(32'd65536 - HDR, 3'd0);
      allocate(32'd1, 3'd0);
      release_random_live();
      allocate(32'd65536 - HDR - 10, 3'd4);
      release_random_live();
      drain();
   endtask

   // Register extremes: a base near the top, a small heap and the largest heap.
   task automatic test_registers();
      write_register(bffla_pkg::REG_BASE_ADDRESS, 48'hFFFF_FFFF_FFF0);
      write_register(bffla_pkg::REG_HEAP_BYTES, 48'hABCD_0000_0020);
      allocate(32'd17, 3'd0);
      allocate(32'd16, 3'd5);
      allocate(32'd16, 3'd0);
      release_random_live();
      drain();
      write_register(bffla_pkg::REG_HEAP_BYTES, 48'h0000_FFFF_FFFF);
      allocate(32'hFFFF_FFF0, 3'd2);
      allocate(32'hF000_0000, 3'd0);
      allocate(32'hFFFF_FFFF, 3'd7);
      allocate(32'h8000_0000, 3'd1);
      release_random_live();
      release_random_live();
      drain();
      write_register(bffla_pkg::REG_BASE_ADDRESS, 48'h0);
      write_register(bffla_pkg::REG_HEAP_BYTES, 48'd65536);
   endtask

   // Fill the record table, then fragment the extent table until it is full.
   task automatic test_table_limits();
      for (int i = 0; i <= NUM_RECORDS; i++) allocate($urandom_range(1, 40), 3'd0);
      for (int i = 0; i < NUM_RECORDS; i += 2) begin
         release_addr(live_addresses[i / 2]);
      end
      while (live_addresses.size() != 0) release_random_live();
      drain();
   endtask

   // The receiver holds off so the block backs up, then the sender waits.
   task automatic test_backpressure();
      hold_requests++;
      for (int i = 0; i < 12; i++) begin
         if (i % 3 == 2) release_random_live();
         else allocate($urandom_range(1, 300), ALIGN_BITS'($urandom()));
      end
      drain();
   endtask

   // Mostly well-formed allocate and free traffic with some noise.
   task automatic test_random_traffic(int count);
      int pick;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 52) begin
            case ($urandom_range(0, 9))
               0:       allocate($urandom(), ALIGN_BITS'($urandom()));
               1:       allocate(32'd0, ALIGN_BITS'($urandom()));
               default: allocate($urandom_range(1, 1500), ALIGN_BITS'($urandom()));
            endcase
         end else if (pick < 90) begin
            release_random_live();
         end else if (pick < 95 && released_addresses.size() != 0) begin
            release_addr(released_addresses[$urandom_range(0,
                                            released_addresses.size() - 1)]);
         end else begin
            release_addr(ADDR_BITS'({$urandom(), $urandom()}));
         end
      end
      drain();
   endtask

   initial begin
      reset               = 1'b1;
      req_valid           = 1'b0;
      req_opcode          = bffla_pkg::OP_ALLOCATE;
      req_request_bytes   = '0;
      req_align_log2      = '0;
      req_release_address = '0;
      csr_valid           = 1'b0;
      csr_index           = bffla_pkg::REG_BASE_ADDRESS;
      csr_wdata           = '0;
      mismatch_count      = 0;
      send_idle_pct       = 38;
      recv_idle_pct       = 63;
      shadow_base         = '0;
      shadow_heap         = bffla_pkg::HEAP_BYTES_RESET;
      heap_clear();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_registers();
      test_table_limits();
      test_backpressure();

      write_register(bffla_pkg::REG_BASE_ADDRESS, ADDR_BITS'({$urandom(), $urandom()}));
      test_random_traffic(275);
      send_idle_pct = 63;
      recv_idle_pct = 38;
      write_register(bffla_pkg::REG_BASE_ADDRESS, ADDR_BITS'({$urandom(), $urandom()}));
      write_register(bffla_pkg::REG_HEAP_BYTES, ADDR_BITS'($urandom_range(4096, 200000)));
      test_random_traffic(275);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_register(bffla_pkg::REG_HEAP_BYTES, 48'h0000_FFFF_FFFF);
      test_random_traffic(275);

      if (mismatch_count == 0 && pending_responses.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

`default_nettype wire
